// File: rtl/apc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_pkg
// Shared constants, register indexes and helpers for the heading PID block.
// ----------------------------------------------------------------------------
package apc_pkg;

  // Field widths
  localparam int DATA_W = 16;
  localparam int IDX_W  = 3;

  // Serial multiplier operand widths (signed)
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Width of the pre-clamp drive sum
  localparam int SUM_W = 28;

  // Angle constants, Q2.13
  localparam logic signed [17:0] PI_Q13     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
  localparam logic [IDX_W-1:0] REG_DRIVE_MIN     = 3'd4;
  localparam logic [IDX_W-1:0] REG_DRIVE_MAX     = 3'd5;
  localparam logic [IDX_W-1:0] REG_INTEG_MIN     = 3'd6;
  localparam logic [IDX_W-1:0] REG_INTEG_MAX     = 3'd7;

  // Register reset values
  localparam logic [DATA_W-1:0] RST_SAMPLE_PERIOD = 16'd655;
  localparam logic signed [DATA_W-1:0] RST_DRIVE_MIN = -16'sd4096;
  localparam logic signed [DATA_W-1:0] RST_DRIVE_MAX = 16'sd4096;
  localparam logic signed [DATA_W-1:0] RST_INTEG_MIN = -16'sd1229;
  localparam logic signed [DATA_W-1:0] RST_INTEG_MAX = 16'sd0;

  // Limit to hi first, then raise to lo: lo wins when the limits cross
  function automatic logic signed [DATA_W-1:0] clamp_lo_wins(
    input logic signed [SUM_W-1:0]  v,
    input logic signed [DATA_W-1:0] lo,
    input logic signed [DATA_W-1:0] hi
  );
    logic signed [SUM_W-1:0] t;
    t = v;
    if (t > SUM_W'(hi)) begin
      t = SUM_W'(hi);
    end
    if (t < SUM_W'(lo)) begin
      t = SUM_W'(lo);
    end
    return t[DATA_W-1:0];
  endfunction

endpackage

// File: rtl/apc_sermul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_sermul
// Signed bit-serial multiplier: one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module apc_sermul #(
  parameter int WA = 33,
  parameter int WB = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [WA-1:0] a_i,
  input  logic signed [WB-1:0] b_i,
  output logic                 done_o,
  output logic [WA+WB-1:0]     prod_o
);

  localparam int CNT_W = (WB > 1) ? $clog2(WB) : 1;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic signed [WA-1:0] a_q, a_d;
  logic [WB-1:0]        b_q, b_d;
  logic signed [WA:0]   hi_q, hi_d;
  logic [WB-1:0]        lo_q, lo_d;

  logic                 last;
  logic signed [WA:0]   a_ext;
  logic signed [WA:0]   addend;
  logic signed [WA:0]   psum;

  // One shift-add step; the sign bit of b carries negative weight
  always_comb begin
    last   = (cnt_q == CNT_W'(WB - 1));
    a_ext  = {a_q[WA-1], a_q};
    addend = '0;
    if (b_q[0]) begin
      addend = last ? -a_ext : a_ext;
    end
    psum = hi_q + addend;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      hi_d   = '0;
      lo_d   = '0;
    end else if (busy_q) begin
      hi_d  = {psum[WA], psum[WA:1]};
      lo_d  = {psum[0], lo_q[WB-1:1]};
      b_d   = {1'b0, b_q[WB-1:1]};
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    b_q  <= b_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[WA-1:0], lo_q};

endmodule

// File: rtl/angle_pid_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_pid_controller
// Heading PID step with wrapped angle error, trapezoidal integrator with
// anti-windup clamp, rate-based derivative and clamped drive output.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+----------------
//  in      | target_angle_i, measured_angle_i,         | in_valid_i /
//          | angular_rate_i                            | in_ready_o
//  out     | drive_o                                   | out_valid_o /
//          |                                           | out_ready_i
//  cfg     | cfg_idx_i, cfg_data_i                     | cfg_we_i
//
// Each item passes an accept state and an error state, then four products
// in turn on a single bit-serial multiplier, then a final sum state. A new
// item is taken only once the previous one has left the sum state.
// Reset clears state and loads register defaults. The output register holds
// a finished drive while the next item is being worked on; the final sum
// waits only if the previous drive is still not taken.
// ----------------------------------------------------------------------------
module angle_pid_controller
  import apc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] target_angle_i,
  input  logic signed [DATA_W-1:0] measured_angle_i,
  input  logic signed [DATA_W-1:0] angular_rate_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] drive_o,
  input  logic                     cfg_we_i,
  input  logic [IDX_W-1:0]         cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ERR  = 3'd1;
  localparam logic [2:0] S_MP   = 3'd2;
  localparam logic [2:0] S_MT   = 3'd3;
  localparam logic [2:0] S_MI   = 3'd4;
  localparam logic [2:0] S_MD   = 3'd5;
  localparam logic [2:0] S_SUM  = 3'd6;

  // Configuration registers
  logic signed [DATA_W-1:0] prop_gain_q, integral_gain_q, deriv_gain_q;
  logic [DATA_W-1:0]        sample_period_q;
  logic signed [DATA_W-1:0] drive_min_q, drive_max_q, integ_min_q, integ_max_q;

  // Control and state
  logic [2:0]               state_q, state_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] integ_q, integ_d;
  logic signed [DATA_W-1:0] last_err_q, last_err_d;

  // Item datapath registers
  logic signed [DATA_W-1:0] tgt_q, meas_q, rate_q;
  logic signed [DATA_W:0]   esum_q, esum_d;
  logic signed [22:0]       p_q, p_d;
  logic signed [26:0]       d_q, d_d;
  logic signed [DATA_W-1:0] drive_q, drive_d;

  // Multiplier interface
  logic                      mul_start;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_done;
  logic [PROD_W-1:0]         mul_prod;

  // Combinational helpers
  logic signed [17:0]       diff;
  logic signed [DATA_W-1:0] err;
  logic signed [23:0]       inc;
  logic signed [33:0]       dneg;
  logic signed [SUM_W-1:0]  integ_sum;
  logic signed [SUM_W-1:0]  total;

  // Wrapped angle error; the trapezoid error sum is formed in S_ERR
  always_comb begin
    diff = 18'(meas_q) - 18'(tgt_q);
  end

  always_comb begin
    if (diff > PI_Q13) begin
      err = DATA_W'(diff - TWO_PI_Q13);
    end else if (diff < -PI_Q13) begin
      err = DATA_W'(diff + TWO_PI_Q13);
    end else begin
      err = DATA_W'(diff);
    end
  end

  // Product post-processing
  always_comb begin
    inc       = $signed(mul_prod[PROD_W-1:26]);
    integ_sum = SUM_W'(integ_q) + SUM_W'(inc);
    dneg      = 34'sd0 - $signed({mul_prod[32], mul_prod[32:0]});
    total     = SUM_W'(p_q) + SUM_W'(integ_q) + SUM_W'(d_q);
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    integ_d     = integ_q;
    last_err_d  = last_err_q;
    esum_d      = esum_q;
    p_d         = p_q;
    d_d         = d_q;
    drive_d     = drive_q;
    mul_start   = 1'b0;
    mul_a       = MUL_A_W'(prop_gain_q);
    mul_b       = MUL_B_W'(err);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        esum_d     = MUL_B_W'(err) + MUL_B_W'(last_err_q);
        last_err_d = err;
        mul_start  = 1'b1;
        mul_a      = MUL_A_W'(prop_gain_q);
        mul_b      = MUL_B_W'(err);
        state_d    = S_MP;
      end
      S_MP: begin
        if (mul_done) begin
          p_d       = $signed(mul_prod[31:9]);
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(integral_gain_q);
          mul_b     = esum_q;
          state_d   = S_MT;
        end
      end
      S_MT: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = $signed(mul_prod[MUL_A_W-1:0]);
          mul_b     = $signed({1'b0, sample_period_q});
          state_d   = S_MI;
        end
      end
      S_MI: begin
        if (mul_done) begin
          integ_d   = clamp_lo_wins(integ_sum, integ_min_q, integ_max_q);
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(deriv_gain_q);
          mul_b     = MUL_B_W'(rate_q);
          state_d   = S_MD;
        end
      end
      S_MD: begin
        if (mul_done) begin
          d_d     = dneg[33:7];
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (!out_valid_q || out_ready_i) begin
          drive_d     = clamp_lo_wins(total, drive_min_q, drive_max_q);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  apc_sermul #(
    .WA (MUL_A_W),
    .WB (MUL_B_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // Control state and controller memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      last_err_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      integ_q     <= integ_d;
      last_err_q  <= last_err_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q     <= '0;
      integral_gain_q <= '0;
      deriv_gain_q    <= '0;
      sample_period_q <= RST_SAMPLE_PERIOD;
      drive_min_q     <= RST_DRIVE_MIN;
      drive_max_q     <= RST_DRIVE_MAX;
      integ_min_q     <= RST_INTEG_MIN;
      integ_max_q     <= RST_INTEG_MAX;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAIN:     prop_gain_q     <= $signed(cfg_data_i);
        REG_INTEGRAL_GAIN: integral_gain_q <= $signed(cfg_data_i);
        REG_DERIV_GAIN:    deriv_gain_q    <= $signed(cfg_data_i);
        REG_SAMPLE_PERIOD: sample_period_q <= cfg_data_i;
        REG_DRIVE_MIN:     drive_min_q     <= $signed(cfg_data_i);
        REG_DRIVE_MAX:     drive_max_q     <= $signed(cfg_data_i);
        REG_INTEG_MIN:     integ_min_q     <= $signed(cfg_data_i);
        REG_INTEG_MAX:     integ_max_q     <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Item capture and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tgt_q  <= target_angle_i;
      meas_q <= measured_angle_i;
      rate_q <= angular_rate_i;
    end
    esum_q  <= esum_d;
    p_q     <= p_d;
    d_q     <= d_d;
    drive_q <= drive_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule

// File: bench/apc_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_drive_checker
// Passive monitor for the heading PID block. It tracks register writes,
// computes the expected drive for every accepted item from its own copy of
// the gains, limits and loop state, and compares each drive taken on the
// output channel with the oldest one waiting.
// ----------------------------------------------------------------------------
module apc_drive_checker
  import apc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic signed [DATA_W-1:0] target_angle_i,
  input  logic signed [DATA_W-1:0] measured_angle_i,
  input  logic signed [DATA_W-1:0] angular_rate_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [DATA_W-1:0] drive_i,
  input  logic                     cfg_we_i,
  input  logic [IDX_W-1:0]         cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  // Half and full turn, Q2.13
  localparam longint HALF_TURN = 25736;
  localparam longint FULL_TURN = 51472;

  // Register shadow
  logic signed [DATA_W-1:0] kp, ki, kd;
  logic        [DATA_W-1:0] period;
  logic signed [DATA_W-1:0] drv_lo, drv_hi, int_lo, int_hi;

  // Loop state
  logic signed [DATA_W-1:0] integ_acc;
  logic signed [DATA_W-1:0] prev_err;

  // Drives still owed by the block, oldest first
  logic signed [DATA_W-1:0] drive_q [$];
  logic signed [DATA_W-1:0] want;
  int                       drives_seen;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: drive %0d: %s", $time, drives_seen, msg);
    fail_count_o++;
  endtask

  // Upper limit first, then the lower one, so crossed limits give lo
  function automatic longint limit_lo_wins(input longint v, input longint lo,
                                           input longint hi);
    longint r;
    r = v;
    if (r > hi) begin
      r = hi;
    end
    if (r < lo) begin
      r = lo;
    end
    return r;
  endfunction

  // One controller step; updates the integrator and the stored error
  function automatic logic signed [DATA_W-1:0] next_drive(
    input logic signed [DATA_W-1:0] tgt,
    input logic signed [DATA_W-1:0] meas,
    input logic signed [DATA_W-1:0] rate
  );
    longint err, p_term, step, d_term, total;
    err = longint'(meas) - longint'(tgt);
    if (err > HALF_TURN) begin
      err = err - FULL_TURN;
    end else if (err < -HALF_TURN) begin
      err = err + FULL_TURN;
    end
    p_term = (longint'(kp) * err) >>> 9;
    // trapezoid: (e + e_prev) / 2 folded into the shift
    step = (longint'(ki) * longint'(period) * (err + longint'(prev_err))) >>> 26;
    integ_acc = DATA_W'(limit_lo_wins(longint'(integ_acc) + step, int_lo, int_hi));
    d_term = (-(longint'(kd) * longint'(rate))) >>> 7;
    total = limit_lo_wins(p_term + longint'(integ_acc) + d_term, drv_lo, drv_hi);
    prev_err = DATA_W'(err);
    return DATA_W'(total);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp = '0;
      ki = '0;
      kd = '0;
      period = RST_SAMPLE_PERIOD;
      drv_lo = RST_DRIVE_MIN;
      drv_hi = RST_DRIVE_MAX;
      int_lo = RST_INTEG_MIN;
      int_hi = RST_INTEG_MAX;
      integ_acc = '0;
      prev_err = '0;
      drive_q.delete();
      drives_seen = 0;
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      // a drive taken at this edge belongs to an older item
      if (out_valid_i && out_ready_i) begin
        if (drive_q.size() == 0) begin
          report_mismatch($sformatf("got %0d with no item waiting", drive_i));
        end else begin
          want = drive_q.pop_front();
          if (drive_i !== want) begin
            report_mismatch($sformatf("got %0d, want %0d", drive_i, want));
          end
        end
        drives_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        drive_q.push_back(next_drive(target_angle_i, measured_angle_i, angular_rate_i));
      end
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROP_GAIN:     kp = cfg_data_i;
          REG_INTEGRAL_GAIN: ki = cfg_data_i;
          REG_DERIV_GAIN:    kd = cfg_data_i;
          REG_SAMPLE_PERIOD: period = cfg_data_i;
          REG_DRIVE_MIN:     drv_lo = cfg_data_i;
          REG_DRIVE_MAX:     drv_hi = cfg_data_i;
          REG_INTEG_MIN:     int_lo = cfg_data_i;
          REG_INTEG_MAX:     int_hi = cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= drive_q.size();
    end
  end

endmodule

// File: bench/tb_angle_pid_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_angle_pid_controller
// Drives angle items into the heading PID block under a series of gain and
// limit settings: a directed set covering angle extremes, error wrap at
// plus and minus pi, crossed clamp limits and a zero period, then random
// items under random settings. Both channels idle at random; one phase runs
// with no idling, one holds the output off long enough to stall the input.
// Checking is done by apc_drive_checker.
// ----------------------------------------------------------------------------
module tb_angle_pid_controller;
  import apc_pkg::*;

  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int RAND_PHASES  = 5;
  localparam int PHASE_ITEMS  = 80;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] target_angle_i;
  logic signed [DATA_W-1:0] measured_angle_i;
  logic signed [DATA_W-1:0] angular_rate_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] drive_o;
  logic                     cfg_we_i;
  logic [IDX_W-1:0]         cfg_idx_i;
  logic [DATA_W-1:0]        cfg_data_i;

  int   fail_count;
  int   pending;
  logic calm;        // no idling on either side
  int   holds_asked; // long output hold requests

  angle_pid_controller dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .target_angle_i   (target_angle_i),
    .measured_angle_i (measured_angle_i),
    .angular_rate_i   (angular_rate_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_o          (drive_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  apc_drive_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .target_angle_i   (target_angle_i),
    .measured_angle_i (measured_angle_i),
    .angular_rate_i   (angular_rate_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_i          (drive_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("tb_angle_pid_controller: errors");
    $finish;
  end

  // Mostly none, often short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(12, 60);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_angle();
    case ($urandom_range(0, 19))
      0:       return -16'sd25736;
      1:       return 16'sd25736;
      2:       return '0;
      default: return DATA_W'($urandom_range(0, 51472) - 25736);
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3:    return DATA_W'($urandom);
      default: return DATA_W'($urandom_range(0, 2047) - 1024);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return 16'd1;
      1:       return 16'hffff;
      2:       return DATA_W'($urandom_range(1, 65535));
      default: return DATA_W'($urandom_range(1, 4000));
    endcase
  endfunction

  // Clamp pair: usually sane, sometimes full scale, crossed or arbitrary
  task automatic pick_limits(output logic [DATA_W-1:0] lo, output logic [DATA_W-1:0] hi);
    int a, b;
    a = -$urandom_range(0, 8192);
    b = $urandom_range(0, 8192);
    case ($urandom_range(0, 9))
      0: begin
        lo = 16'h8000;
        hi = 16'h7fff;
      end
      1: begin
        lo = DATA_W'(b);
        hi = DATA_W'(a);
      end
      2: begin
        lo = DATA_W'($urandom);
        hi = DATA_W'($urandom);
      end
      default: begin
        lo = DATA_W'(a);
        hi = DATA_W'(b);
      end
    endcase
  endtask

  // Write all eight registers on consecutive edges
  task automatic write_settings(
    input logic [DATA_W-1:0] p_gain, i_gain, d_gain, per,
    input logic [DATA_W-1:0] d_lo, d_hi, i_lo, i_hi
  );
    logic [DATA_W-1:0] vals [8];
    vals[REG_PROP_GAIN]     = p_gain;
    vals[REG_INTEGRAL_GAIN] = i_gain;
    vals[REG_DERIV_GAIN]    = d_gain;
    vals[REG_SAMPLE_PERIOD] = per;
    vals[REG_DRIVE_MIN]     = d_lo;
    vals[REG_DRIVE_MAX]     = d_hi;
    vals[REG_INTEG_MIN]     = i_lo;
    vals[REG_INTEG_MAX]     = i_hi;
    for (int k = 0; k < 8; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= IDX_W'(k);
      cfg_data_i <= vals[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_item(input logic signed [DATA_W-1:0] tgt,
                           input logic signed [DATA_W-1:0] meas,
                           input logic signed [DATA_W-1:0] rate);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    target_angle_i   <= tgt;
    measured_angle_i <= meas;
    angular_rate_i   <= rate;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop offering, wait for every owed drive, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Output side
  initial begin : drain_side
    int len;
    int holds_done;
    holds_done = 0;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (holds_asked > holds_done) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        holds_done++;
      end else begin
        len = idle_len();
        if (len > 0) begin
          out_ready_i <= 1'b0;
          repeat (len) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // Input side and verdict
  initial begin : stimulus
    logic [DATA_W-1:0] d_lo, d_hi, i_lo, i_hi;
    calm        = 1'b0;
    holds_asked = 0;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    target_angle_i   <= '0;
    measured_angle_i <= '0;
    angular_rate_i   <= '0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= '0;
    cfg_data_i       <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults
    send_item(16'sd0, 16'sd0, 16'sd0);
    send_item(16'sd0, 16'sd25736, -16'sd32768);
    send_item(-16'sd25736, 16'sd0, 16'sd32767);
    send_item(16'sd12000, -16'sd9000, 16'sd0);
    settle();

    // unit-ish gains, wide limits: angle extremes and error wrap
    write_settings(16'd256, 16'd1024, 16'd64, 16'd655,
                   16'h8000, 16'h7fff, -16'sd8192, 16'sd8192);
    send_item(16'sd0, 16'sd25736, 16'sd0);          // error exactly +pi
    send_item(16'sd0, -16'sd25736, 16'sd0);         // error exactly -pi
    send_item(-16'sd25736, 16'sd25736, 16'sd0);     // full turn wraps to zero
    send_item(-16'sd1, 16'sd25736, 16'sd100);       // just past +pi
    send_item(16'sd1, -16'sd25736, -16'sd100);      // just past -pi
    send_item(16'sd25736, -16'sd25736, 16'sd32767);
    send_item(16'sd25736, 16'sd25736, -16'sd32768);
    send_item(-16'sd25736, -16'sd25736, 16'sd0);
    send_item(16'sd5000, -16'sd3000, 16'sd2048);
    send_item(-16'sd7000, 16'sd8000, -16'sd2048);
    settle();

    // crossed limits on both clamps, zero period, extreme gains
    write_settings(16'h7fff, 16'h8000, 16'h8000, 16'd0,
                   16'sd1000, -16'sd1000, 16'sd500, -16'sd500);
    send_item(16'sd0, 16'sd25736, 16'sd32767);
    send_item(16'sd25736, -16'sd25736, -16'sd32768);
    send_item(-16'sd3000, 16'sd3000, 16'sd0);
    send_item(16'sd0, 16'sd0, 16'sd1);
    settle();

    // full-scale limits, longest period, opposite extreme gains
    write_settings(16'h8000, 16'h7fff, 16'h7fff, 16'hffff,
                   16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_item(16'sd0, 16'sd25736, -16'sd32768);
    send_item(16'sd0, 16'sd25736, 16'sd32767);
    send_item(16'sd25736, 16'sd0, 16'sd0);
    send_item(-16'sd20000, 16'sd20000, 16'sd500);

    // random settings, random items
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      pick_limits(d_lo, d_hi);
      pick_limits(i_lo, i_hi);
      write_settings(pick_gain(), pick_gain(), pick_gain(), pick_period(),
                     d_lo, d_hi, i_lo, i_hi);
      calm = (ph == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // output held off while items keep coming, later a full pause
        if (ph == 2 && n == 10) begin
          holds_asked++;
        end
        if (ph == 2 && n == 50) begin
          settle();
        end
        send_item(pick_angle(), pick_angle(), pick_rate());
      end
    end
    calm = 1'b0;
    settle();

    if (fail_count == 0) begin
      $display("tb_angle_pid_controller: clean");
    end else begin
      $display("tb_angle_pid_controller: errors");
    end
    $finish;
  end

endmodule
